>>> hw/rtl/tsad_pkg.sv
// Shared types, constants and the arctangent table for the two-sensor angle block.
package tsad_pkg;

  localparam int unsigned CFG_W      = 12;
  localparam int unsigned IN_W       = 12;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned GUARD_BITS = 20;
  localparam int unsigned TBL_SIZE   = 22;
  localparam int unsigned TBL_IDX_W  = 5;

  localparam logic [CFG_W-1:0] MIDPOINT_RESET = 12'd2048;
  localparam logic [ACC_W-1:0] HALF_TURN      = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_ROUND,
    ST_PUBLISH
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic round;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // atan(2^-i) in binary-angle units, 2^32 per turn
  function automatic logic [ACC_W-1:0] atan_turn(input logic [TBL_IDX_W-1:0] idx);
    logic [ACC_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> hw/rtl/two_sensor_angle_delta.sv
// Top level of the two-sensor angle delta block.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one pair of smoothed samples per
//   transaction; sample_a_i is the atan2 y operand, sample_b_i the x operand, both
//   centered by the center_value register before use.
//   Output channel (out_valid_o/out_ready_i) returns, per input transaction, the
//   binary angle angle_now_o and the wrapped change angle_delta_o since the last one.
//   center_value_we_i writes center_value_i into the midpoint; write only when idle.
// Timing:
//   An accepted transaction takes a load step, CORDIC_STEPS iterations of the
//   shared shift-add rotation unit, a rounding step and a publish step; in_ready_o
//   rises in the same cycle as out_valid_o, so a new transaction is accepted only
//   after the last one has been published.
// Reset:
//   Clears the stored angle to zero, the midpoint to 2048 and drops out_valid_o.
// Stall:
//   A result held in the output register does not block the next acceptance; the
//   next result waits in the publish step until the output register is taken.
module two_sensor_angle_delta import tsad_pkg::*; #(
  parameter int unsigned SAMPLE_BITS  = 12,
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    center_value_we_i,
  input  logic [CFG_W-1:0]        center_value_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [IN_W-1:0]         sample_a_i,
  input  logic [IN_W-1:0]         sample_b_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] angle_delta_o,
  output logic [OUT_W-1:0]        angle_now_o
);

  localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);

  cmd_t              cmd;
  status_t           status;
  logic [STEP_W-1:0] step;
  logic [OUT_W-1:0]  delta_raw;

  tsad_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .STEP_W       (STEP_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .step_o     (step)
  );

  tsad_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ANGLE_BITS  (ANGLE_BITS),
    .STEP_W      (STEP_W)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .center_value_we_i (center_value_we_i),
    .center_value_i    (center_value_i),
    .sample_a_i        (sample_a_i),
    .sample_b_i        (sample_b_i),
    .cmd_i             (cmd),
    .step_i            (step),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .angle_delta_o     (delta_raw),
    .angle_now_o       (angle_now_o)
  );

  assign angle_delta_o = $signed(delta_raw);

endmodule

>>> hw/rtl/tsad_ctrl.sv
// Sequencer for the two-sensor angle block: load, CORDIC iterations, rounding, publish.
module tsad_ctrl import tsad_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 14,
  parameter int unsigned STEP_W       = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  status_t           status_i,
  output cmd_t              cmd_o,
  output logic [STEP_W-1:0] step_o
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_ITER;
        end
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_ROUND;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  assign step_o = step_q;

`ifndef NO_ASSERTIONS
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ITER) |-> (step_q == '0))
    else $error("step counter nonzero outside iteration");

  a_load_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_ITER) && (step_q == '0))
    else $error("accepted transaction did not start iterating");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER && step_q == LAST_STEP) |=> (state_q == ST_ROUND))
    else $error("last iteration not followed by rounding");

  a_round_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |=> (state_q == ST_PUBLISH))
    else $error("rounding not followed by publish");
`endif

endmodule

>>> hw/rtl/tsad_datapath.sv
// Datapath: centering, vectoring CORDIC registers, rounding, delta and output register.
module tsad_datapath import tsad_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned ANGLE_BITS  = 16,
  parameter int unsigned STEP_W      = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              center_value_we_i,
  input  logic [CFG_W-1:0]  center_value_i,
  input  logic [IN_W-1:0]   sample_a_i,
  input  logic [IN_W-1:0]   sample_b_i,
  input  cmd_t              cmd_i,
  input  logic [STEP_W-1:0] step_i,
  output status_t           status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  angle_delta_o,
  output logic [OUT_W-1:0]  angle_now_o
);

  localparam int unsigned S       = SAMPLE_BITS;
  localparam int unsigned W       = SAMPLE_BITS + GUARD_BITS + 3;
  localparam int unsigned PAD_W   = W - S - 1 - GUARD_BITS;
  localparam int unsigned IEXT_W  = (S > IN_W) ? S : IN_W;
  localparam int unsigned CEXT_W  = (S > CFG_W) ? S : CFG_W;
  localparam int unsigned OEXT_W  = (ANGLE_BITS > OUT_W) ? ANGLE_BITS : OUT_W;
  localparam int unsigned DROP    = ACC_W - ANGLE_BITS;
  localparam logic [ACC_W-1:0] RND_HALF = 32'd1 << (DROP - 1);

  logic [CFG_W-1:0]      midpoint_q;
  logic signed [W-1:0]   x_q, x_d, y_q, y_d;
  logic [ACC_W-1:0]      z_q, z_d;
  logic                  zero_q, zero_d;
  logic [ANGLE_BITS-1:0] angle_q, angle_d;
  logic [ANGLE_BITS-1:0] prev_q, prev_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      delta_out_q, delta_out_d;
  logic [OUT_W-1:0]      now_out_q, now_out_d;

  logic [IEXT_W-1:0]     a_ext, b_ext;
  logic [CEXT_W-1:0]     m_ext;
  logic [S:0]            y_c, x_c, y_n, x_n;
  logic                  neg;
  logic signed [W-1:0]   dx, dy;
  logic [ACC_W-1:0]      ang, z_rnd;
  logic [ANGLE_BITS-1:0] delta;
  logic [OEXT_W-1:0]     delta_ext, now_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midpoint_q  <= MIDPOINT_RESET;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (center_value_we_i) begin
        midpoint_q <= center_value_i;
      end
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    z_q         <= z_d;
    zero_q      <= zero_d;
    angle_q     <= angle_d;
    delta_out_q <= delta_out_d;
    now_out_q   <= now_out_d;
  end

  // centering, folded into the right half plane
  assign a_ext = IEXT_W'(sample_a_i);
  assign b_ext = IEXT_W'(sample_b_i);
  assign m_ext = CEXT_W'(midpoint_q);
  assign y_c   = {1'b0, a_ext[S-1:0]} - {1'b0, m_ext[S-1:0]};
  assign x_c   = {1'b0, b_ext[S-1:0]} - {1'b0, m_ext[S-1:0]};
  assign neg   = x_c[S];
  assign x_n   = neg ? -x_c : x_c;
  assign y_n   = neg ? -y_c : y_c;

  // one micro-rotation
  assign dx  = y_q >>> step_i;
  assign dy  = x_q >>> step_i;
  assign ang = atan_turn(TBL_IDX_W'(step_i));

  assign z_rnd = z_q + RND_HALF;

  assign delta     = angle_q - prev_q;
  assign delta_ext = OEXT_W'(delta);
  assign now_ext   = OEXT_W'(angle_q);

  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    zero_d      = zero_q;
    angle_d     = angle_q;
    prev_d      = prev_q;
    delta_out_d = delta_out_q;
    now_out_d   = now_out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      x_d    = {{PAD_W{x_n[S]}}, x_n, GUARD_BITS'(0)};
      y_d    = {{PAD_W{y_n[S]}}, y_n, GUARD_BITS'(0)};
      z_d    = neg ? HALF_TURN : '0;
      zero_d = (x_c == '0) && (y_c == '0);
    end
    if (cmd_i.step) begin
      if (!y_q[W-1]) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + ang;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - ang;
      end
    end
    if (cmd_i.round) begin
      angle_d = zero_q ? '0 : z_rnd[ACC_W-1 -: ANGLE_BITS];
    end
    if (cmd_i.publish) begin
      delta_out_d = delta_ext[OUT_W-1:0];
      now_out_d   = now_ext[OUT_W-1:0];
      prev_d      = angle_q;
      out_valid_d = 1'b1;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign angle_delta_o     = delta_out_q;
  assign angle_now_o       = now_out_q;

`ifndef NO_ASSERTIONS
  a_pub_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> (prev_q == $past(angle_q)) && out_valid_q)
    else $error("publish did not record angle and raise valid");

  a_pub_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> (!out_valid_q || out_ready_i))
    else $error("publish overwrote an untaken result");

  a_prev_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.publish |=> $stable(prev_q))
    else $error("stored angle changed without publish");
`endif

endmodule
